FILE: hdl/ctt_pkg.sv
// ----------------------------------------------------------------------------
// ctt_pkg: shared types and codes for the callout timer table
// Command, result and table-entry layouts, operation and status codes, and
// the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package ctt_pkg;

  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_REMOVE  = 3'd1;
  localparam logic [2:0] OP_RESET   = 3'd2;
  localparam logic [2:0] OP_QUERY   = 3'd3;
  localparam logic [2:0] OP_PROCESS = 3'd4;
  localparam logic [2:0] OP_TICK    = 3'd5;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_FULL        = 2'd1;
  localparam logic [1:0] STATUS_NO_CALLBACK = 2'd2;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] timer_handle;
    logic [31:0] delay_ticks;
    logic [7:0]  callback_id;
    logic [15:0] callback_arg;
  } ctt_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        fired;
    logic [15:0] fired_handle;
    logic [7:0]  fired_callback;
    logic [15:0] fired_arg;
    logic [31:0] time_left;
    logic [4:0]  active_count;
  } ctt_rsp_t;

  typedef struct packed {
    logic        active;
    logic [15:0] handle;
    logic [7:0]  callback;
    logic [15:0] argument;
    logic [31:0] deadline;
  } ctt_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_FINISH
  } ctt_state_t;

endpackage

`default_nettype wire

FILE: hdl/callout_timer_table.sv
// ----------------------------------------------------------------------------
// callout_timer_table: table of software timers with a tick counter
// Top level joining the entry memory and the scan sequencer.
// ----------------------------------------------------------------------------
// Usage:
// A command item is taken when start is high and busy is low; cmd carries the
// operation and its operands. Every item gives exactly one result item on
// rsp, marked by done for a single cycle; the receiver cannot hold it off.
// Each item reads every table entry in turn, one per cycle through the
// memory's single read port, then writes at most one entry back. busy rises
// the cycle after acceptance; done appears after the closing state, in the
// first cycle with busy low again, and a new item can be taken from then on.
// Reset clears the tick count, the active count and the entry written flags;
// entries never written read as zero, so no clearing pass is run.
// ----------------------------------------------------------------------------
`default_nettype none

module callout_timer_table
  import ctt_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire ctt_cmd_t cmd,
  output      logic     busy,
  output      logic     done,
  output      ctt_rsp_t rsp
);

  localparam int IW = $clog2(ENTRIES);

  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  ctt_entry_t    rd_entry, wr_data;

  ctt_store #(.ENTRIES(ENTRIES)) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  ctt_seq #(.ENTRIES(ENTRIES)) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cmd      (cmd),
    .busy     (busy),
    .done     (done),
    .rsp      (rsp),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

endmodule

`default_nettype wire

FILE: hdl/ctt_store.sv
// ----------------------------------------------------------------------------
// ctt_store: timer entry memory
// One synchronous memory of entries with a registered read port and a write
// port. Per-entry written flags make an entry that was never written read as
// all zeros, which is the table's reset content.
// ----------------------------------------------------------------------------
`default_nettype none

module ctt_store
  import ctt_pkg::*;
#(
  parameter int ENTRIES = 16,
  localparam int IW = $clog2(ENTRIES)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          rd_en,
  input  wire logic [IW-1:0] rd_addr,
  output      ctt_entry_t    rd_entry,
  input  wire logic          wr_en,
  input  wire logic [IW-1:0] wr_addr,
  input  wire ctt_entry_t    wr_data
);

  ctt_entry_t mem [ENTRIES];
  ctt_entry_t rd_q;
  logic       rd_ok;
  logic [ENTRIES-1:0] written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q  <= mem[rd_addr];
      rd_ok <= written[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  assign rd_entry = rd_ok ? rd_q : '0;

endmodule

`default_nettype wire

FILE: hdl/ctt_seq.sv
// ----------------------------------------------------------------------------
// ctt_seq: scan and update sequencer
// Walks the entry memory one address per cycle, picks the entry an operation
// acts on, then writes it back and forms the result in a closing cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ctt_seq
  import ctt_pkg::*;
#(
  parameter int ENTRIES = 16,
  localparam int IW = $clog2(ENTRIES),
  localparam int CW = $clog2(ENTRIES + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire ctt_cmd_t      cmd,
  output      logic          busy,
  output      logic          done,
  output      ctt_rsp_t      rsp,
  output      logic          rd_en,
  output      logic [IW-1:0] rd_addr,
  input  wire ctt_entry_t    rd_entry,
  output      logic          wr_en,
  output      logic [IW-1:0] wr_addr,
  output      ctt_entry_t    wr_data
);

  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  ctt_state_t state, state_next;
  ctt_cmd_t   cmd_q;
  ctt_entry_t hit;
  logic [IW-1:0] rd_idx, chk_idx, sel_idx, fresh_idx;
  logic       chk_valid, found, fresh_found, take;
  logic [31:0] now, now_next, sum;
  logic [CW-1:0] act_cnt, cnt_next;
  logic       upd, wr_req;
  ctt_rsp_t   rsp_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (start) state_next = ST_SCAN;
      ST_SCAN:   if (rd_idx == LAST_IDX) state_next = ST_LAST;
      ST_LAST:   state_next = ST_FINISH;
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  assign busy    = (state != ST_IDLE);
  assign rd_en   = (state == ST_SCAN);
  assign rd_addr = rd_idx;

  // Selection rule for the entry arriving from memory this cycle.
  always_comb begin
    case (cmd_q.op)
      OP_ADD: take = (rd_entry.handle == cmd_q.timer_handle) &&
                     (cmd_q.callback_arg == 16'd0 ||
                      rd_entry.argument == cmd_q.callback_arg);
      OP_REMOVE, OP_RESET, OP_QUERY:
        take = rd_entry.active && (rd_entry.handle == cmd_q.timer_handle);
      OP_PROCESS: take = rd_entry.active && (rd_entry.deadline != 32'd0) &&
                         (now >= rd_entry.deadline);
      default: take = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
    end else begin
      chk_valid <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= rd_idx;
    if (state == ST_IDLE && start) begin
      cmd_q       <= cmd;
      found       <= 1'b0;
      fresh_found <= 1'b0;
      rd_idx      <= '0;
    end else if (state == ST_SCAN) begin
      rd_idx <= rd_idx + 1'b1;
    end
    // The first hit stops further selection; the last free entry seen
    // before it is the highest-index free slot.
    if (chk_valid && !found) begin
      if (take) begin
        found   <= 1'b1;
        sel_idx <= chk_idx;
        hit     <= rd_entry;
      end else if (cmd_q.op == OP_ADD && !rd_entry.active) begin
        fresh_found <= 1'b1;
        fresh_idx   <= chk_idx;
      end
    end
  end

  assign sum = cmd_q.delay_ticks + now;
  assign upd = !found || (cmd_q.callback_arg != 16'd0) ||
               (hit.callback != cmd_q.callback_id);

  always_comb begin
    wr_req   = 1'b0;
    wr_addr  = sel_idx;
    wr_data  = hit;
    rsp_next = '0;
    cnt_next = act_cnt;
    now_next = now;
    case (cmd_q.op)
      OP_ADD: begin
        if (found || fresh_found) begin
          wr_req          = 1'b1;
          wr_addr         = found ? sel_idx : fresh_idx;
          wr_data.active   = 1'b1;
          wr_data.deadline = sum;
          if (upd) begin
            wr_data.handle   = cmd_q.timer_handle;
            wr_data.callback = cmd_q.callback_id;
            wr_data.argument = cmd_q.callback_arg;
          end
          if (!found || !hit.active) begin
            cnt_next = CW'(act_cnt + 1'b1);
          end
        end else begin
          rsp_next.status = STATUS_FULL;
        end
      end
      OP_REMOVE: begin
        if (found) begin
          wr_req         = 1'b1;
          wr_data.active = 1'b0;
          wr_data.handle = '0;
          cnt_next       = CW'(act_cnt - 1'b1);
        end
      end
      OP_RESET: begin
        if (found) begin
          wr_req           = 1'b1;
          wr_data.deadline = sum;
        end
      end
      OP_QUERY: begin
        if (found && hit.deadline > now) begin
          rsp_next.time_left = hit.deadline - now;
        end
      end
      OP_PROCESS: begin
        if (found) begin
          wr_req                  = 1'b1;
          wr_data.active          = 1'b0;
          wr_data.handle          = '0;
          cnt_next                = CW'(act_cnt - 1'b1);
          rsp_next.fired          = 1'b1;
          rsp_next.fired_handle   = hit.handle;
          rsp_next.fired_callback = hit.callback;
          rsp_next.fired_arg      = hit.argument;
          if (hit.callback == 8'd0) begin
            rsp_next.status = STATUS_NO_CALLBACK;
          end
        end
      end
      OP_TICK: now_next = now + 32'd1;
      default: ;
    endcase
    rsp_next.active_count = 5'(cnt_next);
  end

  assign wr_en = (state == ST_FINISH) && wr_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      now     <= '0;
      act_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= (state == ST_FINISH);
      if (state == ST_FINISH) begin
        now     <= now_next;
        act_cnt <= cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ctt_chk.sv
// ----------------------------------------------------------------------------
// ctt_chk: port-level checks for the callout timer table
// Watches the command and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ctt_chk
  import ctt_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     done,
  input wire ctt_rsp_t rsp
);

  // An accepted item keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted item");

  // A result only ends a busy period.
  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $fell(busy))
    else $error("result strobe outside the end of an operation");

  // Every busy period ends with exactly one result.
  a_busy_end_gives_done: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> done)
    else $error("operation finished without a result");

  // A fired entry cannot come with a query figure or a full-table status.
  a_fired_clean: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.fired) |-> (rsp.time_left == 32'd0 && rsp.status != STATUS_FULL))
    else $error("fired result carries unrelated fields");

endmodule

bind callout_timer_table ctt_chk u_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

`default_nettype wire

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the callout timer table
// Commands go in through the start/busy handshake in random bursts. A
// behavioural copy of the timer table predicts each result, and every done
// strobe is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import ctt_pkg::*;

  localparam int ENTRIES        = 16;
  localparam int RANDOM_ITEMS   = 1000;
  localparam int POOL           = 20;
  localparam int WATCHDOG_LIMIT = 400;

  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_NOISE} phase_t;

  logic     clk   = 1'b0;
  logic     rst;
  logic     start = 1'b0;
  ctt_cmd_t cmd   = '0;
  logic     busy;
  logic     done;
  ctt_rsp_t rsp;

  callout_timer_table #(.ENTRIES(ENTRIES)) DUT (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ctt_cmd_t    queued_cmds [$];
  ctt_rsp_t    awaited_rsps [$];
  int          mismatches   = 0;
  int          results_seen = 0;
  int          idle_cycles  = 0;
  int          burst_left   = 1;
  int          gap_left     = 0;
  logic [31:0] ticks_queued = '0;

  // Shadow copy of the timer table, updated as each item is taken.
  ctt_entry_t  slot [ENTRIES];
  logic [31:0] tick_now;

  logic [15:0] handle_pool [POOL];
  logic [15:0] arg_pool [POOL];

  task automatic note_failure(input string msg);
    $display("mismatch at result %0d: %s", results_seen, msg);
    mismatches++;
  endtask

  function automatic int find_live(input logic [15:0] h);
    for (int i = 0; i < ENTRIES; i++)
      if (slot[i].active && slot[i].handle == h) return i;
    return -1;
  endfunction

  function automatic ctt_rsp_t timer_table_step(input ctt_cmd_t c);
    ctt_rsp_t r;
    int       hit;
    int       reuse;
    int       fresh;
    r     = '0;
    hit   = -1;
    reuse = -1;
    fresh = -1;
    case (c.op)
      OP_ADD: begin
        // The first entry with this handle (and this argument, unless it is null)
        // wins, free or not; otherwise the highest-index free entry seen before any match.
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot[i].handle == c.timer_handle &&
              (c.callback_arg == '0 || slot[i].argument == c.callback_arg)) begin
            reuse = i;
            break;
          end
          if (!slot[i].active) fresh = i;
        end
        hit = (reuse >= 0) ? reuse : fresh;
        if (hit < 0) begin
          r.status = STATUS_FULL;
        end else begin
          slot[hit].active   = 1'b1;
          slot[hit].deadline = c.delay_ticks + tick_now;
          if (reuse < 0 || c.callback_arg != '0 || slot[hit].callback != c.callback_id) begin
            slot[hit].argument = c.callback_arg;
            slot[hit].callback = c.callback_id;
            slot[hit].handle   = c.timer_handle;
          end
        end
      end
      OP_REMOVE: begin
        hit = find_live(c.timer_handle);
        if (hit >= 0) begin
          slot[hit].active = 1'b0;
          slot[hit].handle = '0;
        end
      end
      OP_RESET: begin
        hit = find_live(c.timer_handle);
        if (hit >= 0) slot[hit].deadline = c.delay_ticks + tick_now;
      end
      OP_QUERY: begin
        hit = find_live(c.timer_handle);
        if (hit >= 0 && slot[hit].deadline > tick_now)
          r.time_left = slot[hit].deadline - tick_now;
      end
      OP_PROCESS: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot[i].active && slot[i].deadline != '0 && tick_now >= slot[i].deadline) begin
            r.fired          = 1'b1;
            r.fired_handle   = slot[i].handle;
            r.fired_callback = slot[i].callback;
            r.fired_arg      = slot[i].argument;
            if (slot[i].callback == '0) r.status = STATUS_NO_CALLBACK;
            slot[i].active = 1'b0;
            slot[i].handle = '0;
            break;
          end
        end
      end
      OP_TICK: begin
        tick_now = tick_now + 32'd1;
      end
      default: begin
      end
    endcase
    for (int i = 0; i < ENTRIES; i++)
      if (slot[i].active) r.active_count = r.active_count + 5'd1;
    return r;
  endfunction

  task automatic check_result(input ctt_rsp_t got, input ctt_rsp_t want);
    if (got.status != want.status)
      note_failure($sformatf("status got %0d want %0d", got.status, want.status));
    if (got.fired != want.fired)
      note_failure($sformatf("fired got %0d want %0d", got.fired, want.fired));
    if (got.fired_handle != want.fired_handle)
      note_failure($sformatf("fired_handle got %h want %h",
                             got.fired_handle, want.fired_handle));
    if (got.fired_callback != want.fired_callback)
      note_failure($sformatf("fired_callback got %h want %h",
                             got.fired_callback, want.fired_callback));
    if (got.fired_arg != want.fired_arg)
      note_failure($sformatf("fired_arg got %h want %h", got.fired_arg, want.fired_arg));
    if (got.time_left != want.time_left)
      note_failure($sformatf("time_left got %h want %h", got.time_left, want.time_left));
    if (got.active_count != want.active_count)
      note_failure($sformatf("active_count got %0d want %0d",
                             got.active_count, want.active_count));
  endtask

  task automatic queue_cmd(input logic [2:0] op, input logic [15:0] h,
                           input logic [31:0] dly, input logic [7:0] cb,
                           input logic [15:0] arg);
    ctt_cmd_t c;
    c.op           = op;
    c.timer_handle = h;
    c.delay_ticks  = dly;
    c.callback_id  = cb;
    c.callback_arg = arg;
    queued_cmds.push_back(c);
    if (op == OP_TICK) ticks_queued = ticks_queued + 32'd1;
  endtask

  task automatic load_directed();
    queue_cmd(OP_PROCESS, 16'h0000, 32'h0, 8'h00, 16'h0000);
    queue_cmd(OP_QUERY,   16'h0000, 32'h0, 8'h00, 16'h0000);
    queue_cmd(OP_REMOVE,  16'h0000, 32'h0, 8'h00, 16'h0000);
    queue_cmd(OP_SPARE_A, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
    queue_cmd(OP_SPARE_B, 16'h5A5A, 32'h1234_5678, 8'h81, 16'hA5A5);
    // Handle zero with a null argument lands on the free entry at index 0,
    // and a zero deadline means it must never fire.
    queue_cmd(OP_ADD,     16'h0000, 32'h0, 8'h00, 16'h0000);
    queue_cmd(OP_PROCESS, 16'h0000, 32'h0, 8'h00, 16'h0000);
    queue_cmd(OP_QUERY,   16'h0000, 32'h0, 8'h00, 16'h0000);
    queue_cmd(OP_RESET,   16'h0000, 32'd3, 8'h00, 16'h0000);
    queue_cmd(OP_REMOVE,  16'h0000, 32'h0, 8'h00, 16'h0000);
    queue_cmd(OP_ADD,     16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
    queue_cmd(OP_TICK,    16'h0000, 32'h0, 8'h00, 16'h0000);
    queue_cmd(OP_QUERY,   16'hFFFF, 32'h0, 8'h00, 16'h0000);
    // Deadline wraps to zero here.
    queue_cmd(OP_RESET,   16'hFFFF, 32'hFFFF_FFFF, 8'h00, 16'h0000);
    queue_cmd(OP_ADD,     16'h1234, 32'd1, 8'h00, 16'h5555);
    queue_cmd(OP_TICK,    16'h0000, 32'h0, 8'h00, 16'h0000);
    queue_cmd(OP_PROCESS, 16'h0000, 32'h0, 8'h00, 16'h0000);
    // Reuse with a null argument, reuse with an equal one, then a clash.
    queue_cmd(OP_ADD,     16'h00AA, 32'd5, 8'h03, 16'h0101);
    queue_cmd(OP_ADD,     16'h00AA, 32'd9, 8'h03, 16'h0000);
    queue_cmd(OP_ADD,     16'h00AA, 32'd1, 8'h04, 16'h0101);
    queue_cmd(OP_ADD,     16'h00AA, 32'd2, 8'h04, 16'h0202);
    queue_cmd(OP_TICK,    16'h0000, 32'h0, 8'h00, 16'h0000);
    queue_cmd(OP_TICK,    16'h0000, 32'h0, 8'h00, 16'h0000);
    queue_cmd(OP_PROCESS, 16'h0000, 32'h0, 8'h00, 16'h0000);
    queue_cmd(OP_PROCESS, 16'h0000, 32'h0, 8'h00, 16'h0000);
  endtask

  function automatic logic [2:0] pick_op(input phase_t kind);
    int roll;
    roll = $urandom_range(99);
    case (kind)
      PH_FILL:
        return roll < 60 ? OP_ADD : roll < 70 ? OP_TICK : roll < 80 ? OP_QUERY :
               roll < 90 ? OP_PROCESS : roll < 95 ? OP_REMOVE : OP_RESET;
      PH_DRAIN:
        return roll < 35 ? OP_TICK : roll < 75 ? OP_PROCESS : roll < 85 ? OP_QUERY :
               roll < 95 ? OP_REMOVE : OP_ADD;
      PH_MIXED:
        return roll < 25 ? OP_ADD : roll < 35 ? OP_REMOVE : roll < 45 ? OP_RESET :
               roll < 58 ? OP_QUERY : roll < 78 ? OP_PROCESS : roll < 97 ? OP_TICK :
               roll < 98 ? OP_SPARE_A : OP_SPARE_B;
      default:
        return 3'($urandom_range(7));
    endcase
  endfunction

  task automatic load_random();
    phase_t      kind;
    int          made;
    int          span;
    int          idx;
    int          roll;
    logic [2:0]  op;
    logic [15:0] h;
    logic [15:0] arg;
    logic [7:0]  cb;
    logic [31:0] dly;
    made = 0;
    while (made < RANDOM_ITEMS) begin
      kind = phase_t'($urandom_range(3));
      span = $urandom_range(20, 60);
      // Small handles collide often; a few wide ones exercise every bit.
      for (int k = 0; k < POOL; k++) begin
        roll           = $urandom_range(9);
        handle_pool[k] = (roll == 0) ? 16'h0000 :
                         (roll < 7)  ? 16'($urandom_range(1, 24)) : 16'($urandom);
        arg_pool[k]    = ($urandom_range(1) == 0) ? 16'($urandom_range(1, 4)) : 16'($urandom);
      end
      for (int n = 0; n < span; n++) begin
        op  = pick_op(kind);
        idx = $urandom_range(POOL - 1);
        h   = (kind == PH_NOISE) ? 16'($urandom) : handle_pool[idx];
        roll = $urandom_range(9);
        arg = (roll < 4) ? 16'h0000 : (roll < 8) ? arg_pool[idx] : 16'($urandom);
        cb  = ($urandom_range(4) == 0) ? 8'h00 : 8'($urandom);
        roll = $urandom_range(99);
        // Offsetting by the ticks so far makes the deadline land exactly on zero.
        dly = (roll < 55) ? 32'($urandom_range(0, 6)) :
              (roll < 70) ? 32'($urandom_range(0, 40)) :
              (roll < 85) ? 32'h0 - ticks_queued : $urandom;
        queue_cmd(op, h, dly, cb, arg);
        if (op != OP_SPARE_A && op != OP_SPARE_B) made++;
      end
    end
  endtask

  // Driver: offers the head of the queue in bursts, with gaps counted only
  // while the block is free so that they shift the next item's arrival.
  always @(posedge clk) begin
    logic        taken;
    logic [95:0] noise_bits;
    if (rst) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        awaited_rsps.push_back(timer_table_step(cmd));
        void'(queued_cmds.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 20);
        end
      end
      if (start && !taken) begin
        // Item still on offer; hold it.
      end else if (gap_left > 0 || queued_cmds.size() == 0) begin
        if (gap_left > 0 && !busy) gap_left--;
        noise_bits = {$urandom, $urandom, $urandom};
        start <= 1'b0;
        cmd   <= noise_bits[$bits(ctt_cmd_t)-1:0];
      end else begin
        start <= 1'b1;
        cmd   <= queued_cmds[0];
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (awaited_rsps.size() == 0)
        note_failure($sformatf("result with nothing awaited: %h", rsp));
      else
        check_result(rsp, awaited_rsps.pop_front());
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", idle_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst      = 1'b1;
    tick_now = '0;
    for (int i = 0; i < ENTRIES; i++) slot[i] = '0;
    load_directed();
    load_random();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (queued_cmds.size() != 0 || awaited_rsps.size() != 0) @(posedge clk);
    repeat (2 * (ENTRIES + 3)) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: callout_timer_table.f
hdl/ctt_pkg.sv
hdl/ctt_store.sv
hdl/ctt_seq.sv
hdl/callout_timer_table.sv
hdl/ctt_chk.sv
bench/testbench.sv
